/* rtl/core/vertex_project_to_screen_macros.svh */
// ---------------------------------------------------------------------------
// vertex_project_to_screen assertion macros
// Shared concurrent assertion forms for the projection block.
// ---------------------------------------------------------------------------
`ifndef VERTEX_PROJECT_TO_SCREEN_MACROS_SVH
`define VERTEX_PROJECT_TO_SCREEN_MACROS_SVH

// same-cycle implication, held off during reset
`define VPTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define VPTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vpts_pkg.sv */
// ---------------------------------------------------------------------------
// vpts_pkg
// Widths, register indexes and helpers for the vertex projection block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vpts_pkg;

  localparam int COORD_W     = 16;
  localparam int COEFF_W     = 16;
  localparam int LANE_STRIDE = 16;
  localparam int NUM_LANES   = 4;
  localparam int ROW_W       = LANE_STRIDE * NUM_LANES;
  localparam int PROD_W      = COORD_W + COEFF_W;
  localparam int DOT_W       = PROD_W + 2;          // four products
  localparam int SUM_W       = DOT_W + 1;           // x' + w', w' - y'
  localparam int RES_W       = 12;                  // screen resolution
  localparam int HALF_W      = RES_W - 1;
  localparam int NUM_S_W     = SUM_W + RES_W;       // signed numerator
  localparam int NUM_W       = NUM_S_W + 1;         // numerator magnitude
  localparam int DEN_W       = DOT_W;               // |w'| magnitude
  localparam int QW          = 17;                  // quotient bits kept
  localparam int SCR_W       = 16;
  localparam int IDX_W       = 16;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic [ROW_W-1:0] ROW_X_RESET  = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET  = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_W_RESET  = 64'h1000_0000_0000_0000;
  localparam logic [RES_W-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [RES_W-1:0] HEIGHT_RESET = 12'd240;

  localparam logic signed [SCR_W-1:0] SCR_MAX = 16'sh7fff;
  localparam logic signed [SCR_W-1:0] SCR_MIN = 16'sh8000;

  typedef struct packed {
    logic [SCR_W-1:0] value;
    logic             sat;
  } clamp_t;

  // quotient magnitude plus sign to a saturated 16-bit coordinate
  function automatic clamp_t clamp_coord(input logic neg, input logic ovf,
                                         input logic [QW-1:0] q);
    clamp_t r;
    logic [QW-1:0] qn;
    qn = -q;
    r.sat = 1'b0;
    r.value = q[SCR_W-1:0];
    if (ovf) begin
      r.sat = 1'b1;
      r.value = neg ? SCR_MIN : SCR_MAX;
    end else if (!neg) begin
      if (q > QW'(SCR_MAX)) begin
        r.sat = 1'b1;
        r.value = SCR_MAX;
      end
    end else begin
      if (q > QW'(17'd32768)) begin
        r.sat = 1'b1;
        r.value = SCR_MIN;
      end else begin
        r.value = qn[SCR_W-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/vpts_in_if.sv */
// ---------------------------------------------------------------------------
// vpts_in_if
// Vertex request channel: one homogeneous vertex per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface vpts_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        vertex_index;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic signed [15:0] coord_w;
  logic               last_vertex;

  modport source (output valid, vertex_index, coord_x, coord_y, coord_z, coord_w,
                  last_vertex, input ready);
  modport sink (input valid, vertex_index, coord_x, coord_y, coord_z, coord_w,
                last_vertex, output ready);
endinterface
`default_nettype wire

/* rtl/core/vpts_out_if.sv */
// ---------------------------------------------------------------------------
// vpts_out_if
// Screen coordinate request channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface vpts_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_index;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic               zero_w_error;
  logic               saturated;
  logic               out_last;

  modport source (output valid, out_index, screen_x, screen_y, zero_w_error,
                  saturated, out_last, input ready);
  modport sink (input valid, out_index, screen_x, screen_y, zero_w_error,
                saturated, out_last, output ready);
endinterface
`default_nettype wire

/* rtl/core/vpts_cfg_if.sv */
// ---------------------------------------------------------------------------
// vpts_cfg_if
// Register write channel: index and data per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface vpts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/vpts_div.sv */
// ---------------------------------------------------------------------------
// vpts_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vpts_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vpts_pkg::NUM_W-1:0] num,
  input  logic [vpts_pkg::DEN_W-1:0] den,
  output logic [vpts_pkg::QW-1:0]    quo
);
  import vpts_pkg::*;

  // numerator must be below den << QW; the caller flags the rest
  localparam int CMP_W = DEN_W + QW + 1;

  logic [NUM_W-1:0] rem [QW];
  logic [DEN_W-1:0] dd  [QW];
  logic [QW-1:0]    qq  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [CMP_W-1:0] r_in;
    logic [CMP_W-1:0] d_sh;
    logic [DEN_W-1:0] d_in;
    logic [QW-1:0]    q_in;
    logic             take;

    if (s == 0) begin : g_first
      assign r_in = CMP_W'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = CMP_W'(rem[s-1]);
      assign d_in = dd[s-1];
      assign q_in = qq[s-1];
    end

    assign d_sh = CMP_W'(d_in) << (QW - 1 - s);
    assign take = (r_in >= d_sh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? NUM_W'(r_in - d_sh) : NUM_W'(r_in);
        dd[s]  <= d_in;
        qq[s]  <= {q_in[QW-2:0], take};
      end
    end
  end

  assign quo = qq[QW-1];

endmodule
`default_nettype wire

/* rtl/core/vertex_project_to_screen.sv */
// ---------------------------------------------------------------------------
// vertex_project_to_screen
// Matrix transform, perspective divide and viewport map of one vertex.
// ---------------------------------------------------------------------------
// Usage:
//   vtx : vertex requests (index, Q8.8 x/y/z/w, last marker).
//   pix : screen requests (index, pixel x/y, zero-w flag, clamp flag, last).
//   cfg : register writes, always ready; write only while the pipe is empty.
//   Rows x, y and w of the matrix give x', y', w'; then
//     screen_x = hw*(x'+w')/w', screen_y = hh*(w'-y')/w', toward zero,
//   with hw/hh half the screen size, clamped to signed 16 bits.
// Pipeline:
//   6 arithmetic stages, 17 divider stages (one quotient bit each) and the
//   output register lie between a vtx request and its pix request. One
//   vertex per cycle while pix is not stalled (fully pipelined divider).
// Reset (rst, synchronous): pipeline valids cleared, registers to identity
//   x/y/w rows and a 320x240 screen.
// Stall: when pix is held off the whole pipe freezes and vtx.ready drops;
//   nothing is lost or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_project_to_screen_macros.svh"
module vertex_project_to_screen (
  input  logic  clk,
  input  logic  rst,
  vpts_in_if.sink   vtx,
  vpts_out_if.source pix,
  vpts_cfg_if.sink  cfg
);
  import vpts_pkg::*;

  // ---- configuration registers ----
  logic [ROW_W-1:0] row_x, row_y, row_w;
  logic [RES_W-1:0] scr_width, scr_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x      <= ROW_X_RESET;
      row_y      <= ROW_Y_RESET;
      row_w      <= ROW_W_RESET;
      scr_width  <= WIDTH_RESET;
      scr_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW_X:  row_x      <= cfg.data;
        REG_ROW_Y:  row_y      <= cfg.data;
        REG_ROW_W:  row_w      <= cfg.data;
        REG_WIDTH:  scr_width  <= cfg.data[RES_W-1:0];
        REG_HEIGHT: scr_height <= cfg.data[RES_W-1:0];
        default: ;  // unused indexes ignored
      endcase
    end
  end

  // half sizes, unsigned then made non-negative signed
  logic signed [RES_W-1:0] hw_s, hh_s;
  assign hw_s = $signed({1'b0, scr_width[RES_W-1:1]});
  assign hh_s = $signed({1'b0, scr_height[RES_W-1:1]});

  // ---- global advance: frozen while a result waits unclaimed ----
  logic en;
  assign en        = !pix.valid || pix.ready;
  assign vtx.ready = en;

  logic signed [COORD_W-1:0] comp [NUM_LANES];
  assign comp[0] = vtx.coord_x;
  assign comp[1] = vtx.coord_y;
  assign comp[2] = vtx.coord_z;
  assign comp[3] = vtx.coord_w;

  // sideband that rides along every stage
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

  // ---- S1: twelve lane products ----
  logic                     v1;
  tag_t                     t1;
  logic signed [PROD_W-1:0] px [NUM_LANES];
  logic signed [PROD_W-1:0] py [NUM_LANES];
  logic signed [PROD_W-1:0] pw [NUM_LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= '{idx: vtx.vertex_index, last: vtx.last_vertex};
      for (int k = 0; k < NUM_LANES; k++) begin
        px[k] <= $signed(row_x[k*LANE_STRIDE +: COEFF_W]) * comp[k];
        py[k] <= $signed(row_y[k*LANE_STRIDE +: COEFF_W]) * comp[k];
        pw[k] <= $signed(row_w[k*LANE_STRIDE +: COEFF_W]) * comp[k];
      end
    end
  end

  // ---- S2: dot products x', y', w' ----
  logic                    v2;
  tag_t                    t2;
  logic signed [DOT_W-1:0] xp2, yp2, wp2;

  always_ff @(posedge clk) begin
    if (en) begin
      t2  <= t1;
      xp2 <= DOT_W'(px[0]) + DOT_W'(px[1]) + DOT_W'(px[2]) + DOT_W'(px[3]);
      yp2 <= DOT_W'(py[0]) + DOT_W'(py[1]) + DOT_W'(py[2]) + DOT_W'(py[3]);
      wp2 <= DOT_W'(pw[0]) + DOT_W'(pw[1]) + DOT_W'(pw[2]) + DOT_W'(pw[3]);
    end
  end

  // ---- S3: viewport offsets folded in before scaling ----
  logic                    v3;
  tag_t                    t3;
  logic signed [SUM_W-1:0] sx3, sy3;
  logic signed [DOT_W-1:0] wp3;

  always_ff @(posedge clk) begin
    if (en) begin
      t3  <= t2;
      sx3 <= SUM_W'(xp2) + SUM_W'(wp2);
      sy3 <= SUM_W'(wp2) - SUM_W'(yp2);
      wp3 <= wp2;
    end
  end

  // ---- S4: scale by half width / half height ----
  logic                      v4;
  tag_t                      t4;
  logic signed [NUM_S_W-1:0] nx4, ny4;
  logic signed [DOT_W-1:0]   wp4;

  always_ff @(posedge clk) begin
    if (en) begin
      t4  <= t3;
      nx4 <= sx3 * hw_s;
      ny4 <= sy3 * hh_s;
      wp4 <= wp3;
    end
  end

  // ---- S5: magnitudes and quotient signs ----
  logic signed [NUM_W-1:0] nx_ext, ny_ext;
  logic signed [DEN_W:0]   wp_ext;
  logic [NUM_W-1:0]        nx_abs, ny_abs;
  logic [DEN_W-1:0]        wp_abs;
  logic signed [DEN_W:0]   wp_neg;

  always_comb begin
    nx_ext = NUM_W'(nx4);
    ny_ext = NUM_W'(ny4);
    wp_ext = (DEN_W + 1)'(wp4);
    wp_neg = -wp_ext;
    nx_abs = nx_ext[NUM_W-1] ? NUM_W'(-nx_ext) : NUM_W'(nx_ext);
    ny_abs = ny_ext[NUM_W-1] ? NUM_W'(-ny_ext) : NUM_W'(ny_ext);
    wp_abs = wp_ext[DEN_W] ? wp_neg[DEN_W-1:0] : wp_ext[DEN_W-1:0];
  end

  logic             v5;
  tag_t             t5;
  logic [NUM_W-1:0] nx5, ny5;
  logic [DEN_W-1:0] d5;
  logic             negx5, negy5;

  always_ff @(posedge clk) begin
    if (en) begin
      t5    <= t4;
      nx5   <= nx_abs;
      ny5   <= ny_abs;
      d5    <= wp_abs;
      negx5 <= nx4[NUM_S_W-1] ^ wp4[DOT_W-1];
      negy5 <= ny4[NUM_S_W-1] ^ wp4[DOT_W-1];
    end
  end

  // ---- S6: zero w' and quotient range checks ----
  typedef struct packed {
    tag_t tag;
    logic negx;
    logic negy;
    logic ovfx;
    logic ovfy;
    logic zero;
  } side_t;

  logic             v6;
  side_t            s6;
  logic [NUM_W-1:0] nx6, ny6;
  logic [DEN_W-1:0] d6;

  always_ff @(posedge clk) begin
    if (en) begin
      s6.tag  <= t5;
      s6.negx <= negx5;
      s6.negy <= negy5;
      // quotient of more than QW bits cannot be built by the divider
      s6.ovfx <= (nx5 >> QW) >= NUM_W'(d5);
      s6.ovfy <= (ny5 >> QW) >= NUM_W'(d5);
      s6.zero <= (d5 == '0);
      nx6     <= nx5;
      ny6     <= ny5;
      d6      <= d5;
    end
  end

  // ---- divider stages ----
  logic [QW-1:0] qx, qy;

  vpts_div u_div_x (.clk(clk), .en(en), .num(nx6), .den(d6), .quo(qx));
  vpts_div u_div_y (.clk(clk), .en(en), .num(ny6), .den(d6), .quo(qy));

  logic [QW-1:0] dv;
  side_t         sd [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s6;
      for (int i = 1; i < QW; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // ---- output stage: sign, clamp, zero-w override ----
  clamp_t cx, cy;
  side_t  sl;

  always_comb begin
    sl = sd[QW-1];
    cx = clamp_coord(sl.negx, sl.ovfx, qx);
    cy = clamp_coord(sl.negy, sl.ovfy, qy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix.out_index    <= sl.tag.idx;
      pix.out_last     <= sl.tag.last;
      pix.zero_w_error <= sl.zero;
      pix.screen_x     <= sl.zero ? '0 : $signed(cx.value);
      pix.screen_y     <= sl.zero ? '0 : $signed(cy.value);
      pix.saturated    <= !sl.zero && (cx.sat || cy.sat);
    end
  end

  // ---- valid chain ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      dv <= '0;
      pix.valid <= 1'b0;
    end else if (en) begin
      v1 <= vtx.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      dv <= {dv[QW-2:0], v6};
      pix.valid <= dv[QW-1];
    end
  end

  // ---- checks ----
  `VPTS_ASSERT_NOW(a_zero_w_clears, clk, rst,
    pix.valid && pix.zero_w_error,
    pix.screen_x == '0 && pix.screen_y == '0 && !pix.saturated,
    "zero w result carries non-zero coordinates")
  `VPTS_ASSERT_NOW(a_sat_at_rail, clk, rst,
    pix.valid && pix.saturated,
    pix.screen_x == SCR_MAX || pix.screen_x == SCR_MIN ||
    pix.screen_y == SCR_MAX || pix.screen_y == SCR_MIN,
    "clamp flag set with both coordinates inside range")
  `VPTS_ASSERT_NEXT(a_stall_freezes_tail, clk, rst,
    !en,
    dv == $past(dv) && v6 == $past(v6),
    "pipeline moved while output stalled")

endmodule
`default_nettype wire
